### rtl/lazy_range_add_range_sum_tree_assert.svh
// Assertion macros shared by the lazy range-add range-sum tree RTL.
`ifndef LAZY_RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH
`define LAZY_RANGE_ADD_RANGE_SUM_TREE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LRST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrst assertion failed");

// Next-cycle implication, disabled in reset.
`define LRST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrst assertion failed");

`endif

### rtl/lrst_pkg.sv
// Types and constants of the lazy range-add range-sum tree.
`timescale 1ns / 1ps
package lrst_pkg;
   localparam int LEAVES     = 1024;
   localparam int LEAVES_LOG = $clog2(LEAVES);
   localparam int NODES      = 2 * LEAVES;
   localparam int NODE_W     = LEAVES_LOG + 1;
   localparam int IDX_W      = 11;
   localparam int DEPTH_W    = $clog2(LEAVES_LOG + 1);
   localparam int DATA_W     = 32;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_WRITE = 3'd1,
      OP_BUILD = 3'd2,
      OP_ADD   = 3'd3,
      OP_SUM   = 3'd4
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   lo;
      logic [IDX_W-1:0]   hi;
      logic [DATA_W-1:0]  value;
   } item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VISIT,
      ST_NODE,
      ST_CH0,
      ST_CH1,
      ST_DECIDE,
      ST_UP,
      ST_RA,
      ST_RB,
      ST_RC,
      ST_DONE
   } state_type;
endpackage

### rtl/lazy_range_add_range_sum_tree.sv
// Top level of the lazy range-add range-sum segment tree.
//
//  channel | direction | ports
//  req     | in        | req_valid/req_ready, operation, index_lo, index_hi, value
//  rsp     | out       | rsp_valid/rsp_ready, range_total
//
// After reset a clearing pass zeroes all 2048 entries of both stores; req_ready is low then.
// Range add and range sum walk the tree node by node through the single read port of
// each node memory; a full walk visits up to about 40 nodes.
// Build recomputes the 1023 inner nodes in steps RA, RB, RC; clear reruns the clearing pass.
// A two-word queue lets words arrive while the walker is busy or a result waits.
`timescale 1ns / 1ps
module lazy_range_add_range_sum_tree (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_operation,
   input  logic [lrst_pkg::IDX_W-1:0]         req_index_lo,
   input  logic [lrst_pkg::IDX_W-1:0]         req_index_hi,
   input  logic signed [lrst_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lrst_pkg::DATA_W-1:0] rsp_range_total
);
   logic               init_done, item_valid, item_ready;
   lrst_pkg::item_type item;

   lrst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .init_done     (init_done),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_index_lo  (req_index_lo),
      .req_index_hi  (req_index_hi),
      .req_value     (req_value),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item          (item)
   );

   lrst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .init_done       (init_done),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_total (rsp_range_total)
   );
endmodule

### rtl/lrst_front.sv
// Front end: accepts words, drops no-op codes, queues work for the back end.
`timescale 1ns / 1ps
`include "lazy_range_add_range_sum_tree_assert.svh"
module lrst_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           init_done,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_operation,
   input  logic [lrst_pkg::IDX_W-1:0]     req_index_lo,
   input  logic [lrst_pkg::IDX_W-1:0]     req_index_hi,
   input  logic signed [lrst_pkg::DATA_W-1:0] req_value,
   output logic                           item_valid,
   input  logic                           item_ready,
   output lrst_pkg::item_type             item
);
   lrst_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       legal, push, pop;
   lrst_pkg::item_type new_item;

   // classify: unused codes and out-of-range leaf writes do nothing
   always_comb begin
      unique case (req_operation)
         lrst_pkg::OP_CLEAR, lrst_pkg::OP_BUILD,
         lrst_pkg::OP_ADD, lrst_pkg::OP_SUM: legal = 1'b1;
         lrst_pkg::OP_WRITE: legal = (req_index_lo < lrst_pkg::IDX_W'(lrst_pkg::LEAVES));
         default: legal = 1'b0;
      endcase
      new_item.op    = lrst_pkg::op_type'(req_operation);
      new_item.lo    = req_index_lo;
      new_item.hi    = req_index_hi;
      new_item.value = req_value;
   end

   assign req_ready  = init_done && (count_ff != 2'd2);
   assign push       = req_valid && req_ready && legal;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   `LRST_ASSERT_NOW(a_no_take_before_init, clock, reset, !init_done, !req_ready)
endmodule

### rtl/lrst_back.sv
// Back end: tree walker over the sum and pending-add memories.
`timescale 1ns / 1ps
`include "lazy_range_add_range_sum_tree_assert.svh"
module lrst_back (
   input  logic                               clock,
   input  logic                               reset,
   output logic                               init_done,
   input  logic                               item_valid,
   output logic                               item_ready,
   input  lrst_pkg::item_type                 item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lrst_pkg::DATA_W-1:0] rsp_range_total
);
   localparam int NW = lrst_pkg::NODE_W;
   localparam int DW = lrst_pkg::DATA_W;
   localparam int XW = lrst_pkg::IDX_W;
   localparam int PW = lrst_pkg::DEPTH_W;

   logic [DW-1:0] sum_mem  [lrst_pkg::NODES];
   logic [DW-1:0] pend_mem [lrst_pkg::NODES];

   lrst_pkg::state_type state_ff, state_in;
   lrst_pkg::item_type  item_ff, item_in;
   logic [NW-1:0] node_ff, node_in;
   logic [PW-1:0] depth_ff, depth_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [DW-1:0] d_ff, d_in, nsum_ff, nsum_in, tmp_ff, tmp_in, acc_ff, acc_in;
   logic [DW-1:0] total_ff, total_in;
   logic          rsp_valid_ff, rsp_valid_in, init_done_ff, init_done_in;

   logic          sum_we, pend_we;
   logic [NW-1:0] sum_wa, pend_wa, sum_ra, pend_ra;
   logic [DW-1:0] sum_wd, pend_wd, sum_rd_ff, pend_rd_ff;

   logic [PW-1:0] shift_amt;
   logic [XW-1:0] span, a_lo, b_hi;
   logic          disjoint, covered, is_leaf, is_add, is_sum;
   logic [NW-1:0] child_l, child_r;
   logic [DW-1:0] d_now, newsum;

   // node geometry: node covers [a_lo, b_hi)
   always_comb begin
      shift_amt = PW'(lrst_pkg::LEAVES_LOG) - depth_ff;
      span      = XW'(1) << shift_amt;
      a_lo      = XW'(node_ff ^ (NW'(1) << depth_ff)) << shift_amt;
      b_hi      = a_lo + span;
      disjoint  = (item_ff.hi <= a_lo) || (item_ff.lo >= b_hi);
      covered   = (item_ff.lo <= a_lo) && (b_hi <= item_ff.hi);
      is_leaf   = node_ff[NW-1];
      child_l   = {node_ff[NW-2:0], 1'b0};
      child_r   = {node_ff[NW-2:0], 1'b1};
      is_add    = (item_ff.op == lrst_pkg::OP_ADD);
      is_sum    = (item_ff.op == lrst_pkg::OP_SUM);
      // settle amount; a covered add folds its value in
      d_now     = pend_rd_ff + ((is_add && covered && !disjoint) ? item_ff.value : '0);
      newsum    = sum_rd_ff + (d_now << shift_amt);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      node_in      = node_ff;
      depth_in     = depth_ff;
      clr_in       = clr_ff;
      d_in         = d_ff;
      nsum_in      = nsum_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      init_done_in = init_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      item_ready   = 1'b0;
      sum_we       = 1'b0;
      pend_we      = 1'b0;
      sum_wa       = node_ff;
      pend_wa      = node_ff;
      sum_wd       = '0;
      pend_wd      = '0;
      sum_ra       = node_ff;
      pend_ra      = node_ff;
      unique case (state_ff)
         lrst_pkg::ST_CLEAR: begin
            sum_we  = 1'b1;
            pend_we = 1'b1;
            sum_wa  = clr_ff;
            pend_wa = clr_ff;
            clr_in  = clr_ff + NW'(1);
            if (clr_ff == '1) begin
               init_done_in = 1'b1;
               state_in     = lrst_pkg::ST_IDLE;
            end
         end
         lrst_pkg::ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               item_in  = item;
               node_in  = NW'(1);
               depth_in = '0;
               acc_in   = '0;
               unique case (item.op)
                  lrst_pkg::OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = lrst_pkg::ST_CLEAR;
                  end
                  lrst_pkg::OP_WRITE: begin
                     sum_we = 1'b1;
                     sum_wa = {1'b1, item.lo[lrst_pkg::LEAVES_LOG-1:0]};
                     sum_wd = item.value;
                  end
                  lrst_pkg::OP_BUILD: begin
                     node_in  = NW'(lrst_pkg::LEAVES - 1);
                     state_in = lrst_pkg::ST_RA;
                  end
                  lrst_pkg::OP_ADD, lrst_pkg::OP_SUM: state_in = lrst_pkg::ST_VISIT;
                  default: state_in = lrst_pkg::ST_IDLE;
               endcase
            end
         end
         lrst_pkg::ST_VISIT: begin
            if (is_sum && disjoint) begin
               state_in = lrst_pkg::ST_UP;
            end else begin
               state_in = lrst_pkg::ST_NODE;
            end
         end
         lrst_pkg::ST_NODE: begin
            // settle this node, then hand a nonzero amount to the children of an inner node
            d_in    = d_now;
            nsum_in = newsum;
            sum_we  = 1'b1;
            sum_wd  = newsum;
            pend_we = 1'b1;
            pend_ra = child_l;
            if (!is_leaf && (d_now != '0)) begin
               state_in = lrst_pkg::ST_CH0;
            end else begin
               state_in = lrst_pkg::ST_DECIDE;
            end
         end
         lrst_pkg::ST_CH0: begin
            pend_we  = 1'b1;
            pend_wa  = child_l;
            pend_wd  = pend_rd_ff + d_ff;
            pend_ra  = child_r;
            state_in = lrst_pkg::ST_CH1;
         end
         lrst_pkg::ST_CH1: begin
            pend_we  = 1'b1;
            pend_wa  = child_r;
            pend_wd  = pend_rd_ff + d_ff;
            state_in = lrst_pkg::ST_DECIDE;
         end
         lrst_pkg::ST_DECIDE: begin
            if (disjoint) begin
               state_in = lrst_pkg::ST_UP;
            end else if (covered) begin
               if (is_sum) begin
                  acc_in = acc_ff + nsum_ff;
               end
               state_in = lrst_pkg::ST_UP;
            end else begin
               node_in  = child_l;
               depth_in = depth_ff + PW'(1);
               state_in = lrst_pkg::ST_VISIT;
            end
         end
         lrst_pkg::ST_UP: begin
            if (node_ff == NW'(1)) begin
               state_in = is_sum ? lrst_pkg::ST_DONE : lrst_pkg::ST_IDLE;
            end else if (!node_ff[0]) begin
               node_in  = node_ff + NW'(1);
               state_in = lrst_pkg::ST_VISIT;
            end else begin
               node_in  = node_ff >> 1;
               depth_in = depth_ff - PW'(1);
               state_in = is_add ? lrst_pkg::ST_RA : lrst_pkg::ST_UP;
            end
         end
         lrst_pkg::ST_RA: begin
            sum_ra   = child_l;
            state_in = lrst_pkg::ST_RB;
         end
         lrst_pkg::ST_RB: begin
            tmp_in   = sum_rd_ff;
            sum_ra   = child_r;
            state_in = lrst_pkg::ST_RC;
         end
         lrst_pkg::ST_RC: begin
            // node sum from its two children
            sum_we = 1'b1;
            sum_wd = tmp_ff + sum_rd_ff;
            if (item_ff.op == lrst_pkg::OP_BUILD) begin
               if (node_ff == NW'(1)) begin
                  state_in = lrst_pkg::ST_IDLE;
               end else begin
                  node_in  = node_ff - NW'(1);
                  state_in = lrst_pkg::ST_RA;
               end
            end else begin
               state_in = lrst_pkg::ST_UP;
            end
         end
         lrst_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               total_in     = acc_ff;
               state_in     = lrst_pkg::ST_IDLE;
            end
         end
         default: state_in = lrst_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         init_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         init_done_ff <= init_done_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      node_ff  <= node_in;
      depth_ff <= depth_in;
      d_ff     <= d_in;
      nsum_ff  <= nsum_in;
      tmp_ff   <= tmp_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_ra];
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      pend_rd_ff <= pend_mem[pend_ra];
   end

   assign init_done       = init_done_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = total_ff;

   `LRST_ASSERT_NOW(a_visit_depth, clock, reset,
      state_ff == lrst_pkg::ST_VISIT, (node_ff >> depth_ff) == NW'(1))
   `LRST_ASSERT_NOW(a_child_inner, clock, reset,
      state_ff == lrst_pkg::ST_CH0, !node_ff[NW-1])
   `LRST_ASSERT_NXT(a_done_delivers, clock, reset,
      state_ff == lrst_pkg::ST_DONE && !(rsp_valid_ff && !rsp_ready), rsp_valid_ff)
endmodule
